// ===== hdl/pscr_pkg.sv =====
// ----------------------------------------------------------------------------
// pscr_pkg
// Shared types and constants of the proxy scan result cache.
// ----------------------------------------------------------------------------
package pscr_pkg;

    localparam int DEPTH      = 64;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_W      = 7;
    localparam int ST_W       = 3;
    localparam int AGE_W      = 64;
    localparam int KEY_W      = 56;
    localparam int SLOT_W     = 6;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 16;

    localparam logic [ST_W-1:0] ST_FREE    = 3'd0;
    localparam logic [ST_W-1:0] ST_TIMEOUT = 3'd5;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_PICK = 1'b1;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_entry;

    // Command broadcast to every cell.
    typedef struct packed {
        logic            wr;
        logic            touch;
        logic [IDX_W-1:0] idx;
        t_entry          data;
    } t_cell_cmd;

    // Word passed down the chain while scanning.
    typedef struct packed {
        logic             found_free;
        logic [IDX_W-1:0] free_idx;
        logic             found_hit;
        logic [IDX_W-1:0] hit_idx;
        logic [ST_W-1:0]  hit_status;
        logic             found_vic;
        logic [IDX_W-1:0] vic_idx;
        logic [ST_W-1:0]  vic_status;
        logic [AGE_W-1:0] vic_age;
    } t_scan;

endpackage

// ===== hdl/proxy_scan_result_cache.sv =====
// ----------------------------------------------------------------------------
// proxy_scan_result_cache
// Fully associative cache of proxy check results with class/age eviction.
// ----------------------------------------------------------------------------
// Each word is scanned through a chain of DEPTH slot cells, one cell per
// cycle. The result word is registered in the writeback state and shown
// in S_OUT; the next word is taken in the cycle after the result is
// accepted, so no new request is taken before the last result is accepted.
// The table is empty after reset and the active slot count r_cfg resets to 64.
module proxy_scan_result_cache (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[0], status_in[3:1], address[35:4], port_num[51:36],
    // proxy_kind[59:52], timestamp[123:60], zero[127:124]
    input  logic [pscr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_status[2:0], hit[3], slot_index[9:4], evicted[10], zero[15:11]
    output logic [pscr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [pscr_pkg::CFG_W-1:0] cfg_data
);
    import pscr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WB   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_req;
    logic [ST_W-1:0]  r_st;
    logic [KEY_W-1:0] r_key;
    logic [AGE_W-1:0] r_ts;
    logic [OUT_DATA_W-1:0] r_out;
    t_cell_cmd        cmd;
    t_scan            chain [DEPTH+1];
    logic [CNT_W-1:0] nact;
    logic [IDX_W-1:0] slot;
    logic             ev;

    always_comb begin
        if (r_cfg == '0) nact = CNT_W'(1);
        else if ({{(CNT_W > CFG_W ? CNT_W-CFG_W : 1){1'b0}}, r_cfg} > DEPTH)
            nact = CNT_W'(DEPTH);
        else nact = CNT_W'(r_cfg);
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pscr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_my_idx(IDX_W'(g)),
            .i_cmd   (cmd),
            .i_active(CNT_W'(g) < nact),
            .i_key   (r_key),
            .i_scan  (chain[g]),
            .o_scan  (chain[g+1])
        );
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign cfg_ready     = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;

    assign ev   = !chain[DEPTH].found_free;
    assign slot = chain[DEPTH].found_free ? chain[DEPTH].free_idx : chain[DEPTH].vic_idx;

    always_comb begin
        cmd            = '0;
        cmd.data.key   = r_key;
        cmd.data.age   = r_ts;
        cmd.data.status = r_st;
        if (r_state == S_WB) begin
            if (r_req == REQ_PICK) begin
                cmd.touch = chain[DEPTH].found_hit;
                cmd.idx   = chain[DEPTH].hit_idx;
            end else begin
                cmd.wr  = (r_st <= ST_TIMEOUT);
                cmd.idx = slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= CFG_W'(64);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (cfg_valid) r_cfg <= cfg_data;
                    if (s_axis_tvalid) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DEPTH)) r_state <= S_WB;
                end
                S_WB:   r_state <= S_OUT;
                S_OUT:  if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_req <= s_axis_tdata[0];
            r_st  <= s_axis_tdata[3:1];
            r_key <= s_axis_tdata[59:4];
            r_ts  <= s_axis_tdata[123:60];
        end
        if (r_state == S_WB) begin
            r_out <= '0;
            if (r_req == REQ_PICK) begin
                if (chain[DEPTH].found_hit) begin
                    r_out[2:0] <= chain[DEPTH].hit_status;
                    r_out[3]   <= 1'b1;
                    r_out[9:4] <= SLOT_W'(chain[DEPTH].hit_idx);
                end
            end else if (r_st <= ST_TIMEOUT) begin
                r_out[2:0] <= r_st;
                r_out[9:4] <= SLOT_W'(slot);
                r_out[10]  <= ev;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
    a_wb_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |=> (r_state == S_OUT))
        else $error("writeback did not end");

endmodule

// ===== hdl/pscr_cell.sv =====
// ----------------------------------------------------------------------------
// pscr_cell
// One table slot: holds an entry, folds it into the passing scan word.
// ----------------------------------------------------------------------------
module pscr_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [pscr_pkg::IDX_W-1:0] i_my_idx,
    input  pscr_pkg::t_cell_cmd i_cmd,
    input  logic                i_active,
    input  logic [pscr_pkg::KEY_W-1:0] i_key,
    input  pscr_pkg::t_scan     i_scan,
    output pscr_pkg::t_scan     o_scan
);
    import pscr_pkg::*;

    logic [ST_W-1:0]  r_status;
    logic [KEY_W-1:0] r_key;
    logic [AGE_W-1:0] r_age;
    t_scan            n_scan;
    logic             sel;

    assign sel = (i_cmd.idx == i_my_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_FREE;
        end else if (i_cmd.wr && sel) begin
            r_status <= i_cmd.data.status;
        end
        if (i_cmd.wr && sel) begin
            r_key <= i_cmd.data.key;
            r_age <= i_cmd.data.age;
        end else if (i_cmd.touch && sel) begin
            r_age <= i_cmd.data.age;
        end
    end

    // victim order: lower class first, then older, earlier index wins ties
    always_comb begin
        n_scan = i_scan;
        if (i_active) begin
            if (r_status == ST_FREE) begin
                if (!i_scan.found_free) begin
                    n_scan.found_free = 1'b1;
                    n_scan.free_idx   = i_my_idx;
                end
            end else begin
                if (!i_scan.found_hit && r_key == i_key) begin
                    n_scan.found_hit  = 1'b1;
                    n_scan.hit_idx    = i_my_idx;
                    n_scan.hit_status = r_status;
                end
                if (!i_scan.found_vic || r_status < i_scan.vic_status ||
                    (r_status == i_scan.vic_status && r_age < i_scan.vic_age)) begin
                    n_scan.found_vic  = 1'b1;
                    n_scan.vic_idx    = i_my_idx;
                    n_scan.vic_status = r_status;
                    n_scan.vic_age    = r_age;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_scan <= n_scan;
    end

endmodule
